// ----- sv/i2cra_pkg.sv -----
// Shared types, codes and constants of the I2C register access master.
`timescale 1ns / 1ps
`default_nettype none
package i2cra_pkg;

	// Command codes carried with each tick.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Sequencer phase codes.
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_START_A = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ADDR_W  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_ACK_A   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_REG     = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ACK_R   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_DATA    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ACK_D   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_STOP    = 4'd8;
	localparam logic [PHASE_W-1:0] PH_START_B = 4'd9;
	localparam logic [PHASE_W-1:0] PH_ADDR_R  = 4'd10;
	localparam logic [PHASE_W-1:0] PH_ACK_B   = 4'd11;
	localparam logic [PHASE_W-1:0] PH_RECV    = 4'd12;
	localparam logic [PHASE_W-1:0] PH_MNACK   = 4'd13;

	// Target address after reset.
	localparam logic [6:0] SLAVE_ADDR_RESET = 7'd104;

	// Payload of one tick.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	// Payload of one result.
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_seen;
	} result_t;

	typedef logic [6:0] slave_addr_t;

endpackage
`default_nettype wire

// ----- sv/i2cra_chan_if.sv -----
// Valid/ready channel interface used by every port of the I2C register access master.
`timescale 1ns / 1ps
`default_nettype none
interface i2cra_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/i2c_register_access_master.sv -----
// Top level of the bit-banged I2C master for single-register writes and reads.
//
//  channel | role | payload                                   | transfer
//  --------+------+-------------------------------------------+--------------------------
//  req     | sink | command, reg_addr, write_data, sda_in     | one pin-update tick
//  rsp     | src  | scl_out, sda_out, busy_res, done_res,     | one result per tick
//          |      | read_data, nack_seen                      |
//  cfg     | sink | slave_addr (7 bits)                       | register write, always ready
//
// Each tick is handled on the edge at which it is accepted: the sequencer state advances
// on that edge, and the result lands in the output register on that same edge.
// A new tick is taken in every cycle as long as the output register is empty or
// is being emptied in that cycle. When rsp stalls, req is held off and state freezes.
// arst_n returns the sequencer to idle with both bus lines released and the target
// address at 104.
`timescale 1ns / 1ps
`default_nettype none
module i2c_register_access_master
	import i2cra_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	i2cra_chan_if.sink   req,
	i2cra_chan_if.source rsp,
	i2cra_chan_if.sink   cfg
);

	// Sequencer and datapath state.
	logic [PHASE_W-1:0] phase_q;
	logic [1:0]         sub_step_q;
	logic [3:0]         bit_count_q;
	logic [7:0]         shift_byte_q;
	logic [7:0]         held_register_q;
	logic [7:0]         held_data_q;
	logic               is_read_q;
	logic [7:0]         received_byte_q;
	logic               ack_fault_q;
	logic               scl_q;
	logic               sda_q;
	slave_addr_t        slave_addr_q;

	// Output register.
	logic    valid_s1;
	result_t res_s1;

	// Next-state values for one tick.
	logic [PHASE_W-1:0] ph;
	logic [1:0]         sub;
	logic [3:0]         bc;
	logic [7:0]         sh;
	logic [7:0]         hreg;
	logic [7:0]         hdat;
	logic               rd;
	logic [7:0]         rx;
	logic               fault;
	logic               scl;
	logic               sda;
	logic               done;
	logic               fin;
	logic               run;
	logic [PHASE_W-1:0] ph_next;

	logic tick_acc;

	// A tick may enter whenever the output register will be free at this edge.
	assign req.ready = !valid_s1 || rsp.ready;
	assign tick_acc  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid = valid_s1;
	assign rsp.data  = res_s1;

	// One tick of the bus sequence: the segment step of the current phase, then
	// the move into the next phase when the segment finishes.
	always_comb begin
		ph    = phase_q;
		sub   = sub_step_q;
		bc    = bit_count_q;
		sh    = shift_byte_q;
		hreg  = held_register_q;
		hdat  = held_data_q;
		rd    = is_read_q;
		rx    = received_byte_q;
		fault = ack_fault_q;
		scl   = scl_q;
		sda   = sda_q;
		done  = 1'b0;
		fin   = 1'b0;
		run   = 1'b1;
		ph_next = PH_IDLE;

		// An idle sequencer starts a transaction on a write or read command and
		// performs the first start step in the same tick.
		if (phase_q == PH_IDLE || phase_q > PH_MNACK) begin
			ph  = PH_IDLE;
			run = 1'b0;
			if (req.data.command == CMD_WRITE || req.data.command == CMD_READ) begin
				hreg  = req.data.reg_addr;
				hdat  = req.data.write_data;
				rd    = (req.data.command == CMD_READ);
				fault = 1'b0;
				ph    = PH_START_A;
				sub   = 2'd0;
				bc    = 4'd0;
				run   = 1'b1;
			end
		end

		if (run) begin
			unique case (ph) inside
				PH_START_A, PH_START_B: begin
					case (sub)
						2'd0: sda = 1'b1;
						2'd1: scl = 1'b1;
						2'd2: sda = 1'b0;
						default: begin
							scl = 1'b0;
							fin = 1'b1;
						end
					endcase
					sub = sub + 2'd1;
				end
				PH_ADDR_W, PH_REG, PH_DATA, PH_ADDR_R: begin
					// Bit out, clock high, clock low.
					if (sub == 2'd0) begin
						sda = sh[7];
						sh  = {sh[6:0], 1'b0};
						sub = 2'd1;
					end else if (sub == 2'd1) begin
						scl = 1'b1;
						sub = 2'd2;
					end else begin
						scl = 1'b0;
						sub = 2'd0;
						bc  = bc + 4'd1;
						fin = bc[3];
					end
				end
				PH_ACK_A, PH_ACK_R, PH_ACK_D, PH_ACK_B: begin
					case (sub)
						2'd0: sda = 1'b1;
						2'd1: scl = 1'b1;
						2'd2: fault = fault | req.data.sda_in;
						default: begin
							scl = 1'b0;
							fin = 1'b1;
						end
					endcase
					sub = sub + 2'd1;
				end
				PH_RECV: begin
					// SDA is released once, then each bit is clocked and sampled.
					case (sub)
						2'd0: begin
							sda = 1'b1;
							sub = 2'd1;
						end
						2'd1: begin
							scl = 1'b1;
							sub = 2'd2;
						end
						2'd2: begin
							sh  = {sh[6:0], req.data.sda_in};
							sub = 2'd3;
						end
						default: begin
							scl = 1'b0;
							sub = 2'd1;
							bc  = bc + 4'd1;
							if (bc[3]) begin
								rx  = sh;
								fin = 1'b1;
							end
						end
					endcase
				end
				PH_MNACK: begin
					case (sub)
						2'd0: sda = 1'b1;
						2'd1: scl = 1'b1;
						default: begin
							scl = 1'b0;
							fin = 1'b1;
						end
					endcase
					sub = sub + 2'd1;
				end
				PH_STOP: begin
					case (sub)
						2'd0: sda = 1'b0;
						2'd1: scl = 1'b1;
						default: begin
							sda  = 1'b1;
							fin  = 1'b1;
							done = 1'b1;
						end
					endcase
					sub = sub + 2'd1;
				end
				default: ph = PH_IDLE;
			endcase

			// Successor of each phase once its segment completes.
			unique case (ph)
				PH_START_A: ph_next = PH_ADDR_W;
				PH_ADDR_W:  ph_next = PH_ACK_A;
				PH_ACK_A:   ph_next = PH_REG;
				PH_REG:     ph_next = PH_ACK_R;
				PH_ACK_R:   ph_next = rd ? PH_START_B : PH_DATA;
				PH_DATA:    ph_next = PH_ACK_D;
				PH_ACK_D:   ph_next = PH_STOP;
				PH_START_B: ph_next = PH_ADDR_R;
				PH_ADDR_R:  ph_next = PH_ACK_B;
				PH_ACK_B:   ph_next = PH_RECV;
				PH_RECV:    ph_next = PH_MNACK;
				PH_MNACK:   ph_next = PH_STOP;
				default:    ph_next = PH_IDLE;
			endcase

			if (fin) begin
				ph  = ph_next;
				sub = 2'd0;
				bc  = 4'd0;
				case (ph_next)
					PH_ADDR_W: sh = {slave_addr_q, 1'b0};
					PH_ADDR_R: sh = {slave_addr_q, 1'b1};
					PH_REG:    sh = hreg;
					PH_DATA:   sh = hdat;
					PH_RECV:   sh = 8'd0;
					default:   sh = sh;
				endcase
			end
		end
	end

	// State advances only on accepted ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			sub_step_q      <= 2'd0;
			bit_count_q     <= 4'd0;
			shift_byte_q    <= 8'd0;
			held_register_q <= 8'd0;
			held_data_q     <= 8'd0;
			is_read_q       <= 1'b0;
			received_byte_q <= 8'd0;
			ack_fault_q     <= 1'b0;
			scl_q           <= 1'b1;
			sda_q           <= 1'b1;
		end else if (tick_acc) begin
			phase_q         <= ph;
			sub_step_q      <= sub;
			bit_count_q     <= bc;
			shift_byte_q    <= sh;
			held_register_q <= hreg;
			held_data_q     <= hdat;
			is_read_q       <= rd;
			received_byte_q <= rx;
			ack_fault_q     <= fault;
			scl_q           <= scl;
			sda_q           <= sda;
		end
	end

	// Target address register; the user must write it only while the master is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			slave_addr_q <= cfg.data;
		end
	end

	// Output register: loaded with the result of every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			res_s1.scl_out   <= scl;
			res_s1.sda_out   <= sda;
			res_s1.busy_res  <= (ph != PH_IDLE);
			res_s1.done_res  <= done;
			res_s1.read_data <= rx;
			res_s1.nack_seen <= fault;
		end
	end

	// A completed stop always leaves the master idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.done_res) |-> !res_s1.busy_res)
		else $error("done reported while still busy");

	// Each tick changes at most one bus line.
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> !((scl_q != $past(scl_q)) && (sda_q != $past(sda_q))))
		else $error("both bus lines changed in one tick");

	// The sequencer never lands on an unused phase code.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_MNACK)
		else $error("sequencer reached an unused phase");

	// A command taken while idle begins the start condition.
	a_cmd_start: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && phase_q == PH_IDLE
			&& (req.data.command == CMD_WRITE || req.data.command == CMD_READ))
		|=> (phase_q == PH_START_A && sub_step_q == 2'd1))
		else $error("command did not start a transaction");

endmodule
`default_nettype wire

// ----- tb/sv/i2cra_bus_checker.sv -----
// Checker that predicts every pin-update result of the I2C register access master and compares.
`timescale 1ns / 1ps
module i2cra_bus_checker
	import i2cra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  tick_t       req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  result_t     rsp_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  slave_addr_t cfg_data,
	output int          fail_count,
	output int          pending,
	output logic        seq_busy
);

	// Predicted sequencer state, updated once per accepted tick.
	logic [PHASE_W-1:0] ph = PH_IDLE;
	logic [1:0]         sub = '0;
	logic [3:0]         nbits = '0;
	logic [7:0]         shreg = '0;
	logic [7:0]         hold_reg = '0;
	logic [7:0]         hold_dat = '0;
	logic               rd_mode = 1'b0;
	logic [7:0]         rx_byte = '0;
	logic               ack_fault = 1'b0;
	logic               scl_lvl = 1'b1;
	logic               sda_lvl = 1'b1;
	slave_addr_t        target = SLAVE_ADDR_RESET;

	result_t pin_results_q[$];
	result_t due;
	int      mismatches = 0;

	assign fail_count = mismatches;
	assign pending    = pin_results_q.size();
	assign seq_busy   = (ph != PH_IDLE);

	function automatic void open_phase(input logic [PHASE_W-1:0] p);
		ph    = p;
		sub   = '0;
		nbits = '0;
		case (p)
			PH_ADDR_W: shreg = {target, 1'b0};
			PH_ADDR_R: shreg = {target, 1'b1};
			PH_REG:    shreg = hold_reg;
			PH_DATA:   shreg = hold_dat;
			PH_RECV:   shreg = '0;
			default:   ;
		endcase
	endfunction

	function automatic logic gen_start();
		case (sub)
			2'd0: sda_lvl = 1'b1;
			2'd1: scl_lvl = 1'b1;
			2'd2: sda_lvl = 1'b0;
			default: begin
				scl_lvl = 1'b0;
				return 1'b1;
			end
		endcase
		sub = sub + 2'd1;
		return 1'b0;
	endfunction

	function automatic logic shift_out_bit();
		if (sub == 2'd0) begin
			sda_lvl = shreg[7];
			shreg   = {shreg[6:0], 1'b0};
			sub     = 2'd1;
			return 1'b0;
		end
		if (sub == 2'd1) begin
			scl_lvl = 1'b1;
			sub     = 2'd2;
			return 1'b0;
		end
		scl_lvl = 1'b0;
		sub     = 2'd0;
		nbits   = nbits + 4'd1;
		return (nbits >= 4'd8);
	endfunction

	function automatic logic target_ack(input logic sda);
		case (sub)
			2'd0: sda_lvl = 1'b1;
			2'd1: scl_lvl = 1'b1;
			2'd2: if (sda) ack_fault = 1'b1;
			default: begin
				scl_lvl = 1'b0;
				return 1'b1;
			end
		endcase
		sub = sub + 2'd1;
		return 1'b0;
	endfunction

	function automatic logic shift_in_bit(input logic sda);
		case (sub)
			2'd0: begin
				sda_lvl = 1'b1;
				sub     = 2'd1;
			end
			2'd1: begin
				scl_lvl = 1'b1;
				sub     = 2'd2;
			end
			2'd2: begin
				shreg = {shreg[6:0], sda};
				sub   = 2'd3;
			end
			default: begin
				scl_lvl = 1'b0;
				sub     = 2'd1;
				nbits   = nbits + 4'd1;
				if (nbits >= 4'd8) begin
					rx_byte = shreg;
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic master_nack();
		case (sub)
			2'd0: sda_lvl = 1'b1;
			2'd1: scl_lvl = 1'b1;
			default: begin
				scl_lvl = 1'b0;
				return 1'b1;
			end
		endcase
		sub = sub + 2'd1;
		return 1'b0;
	endfunction

	function automatic logic gen_stop();
		case (sub)
			2'd0: sda_lvl = 1'b0;
			2'd1: scl_lvl = 1'b1;
			default: begin
				sda_lvl = 1'b1;
				return 1'b1;
			end
		endcase
		sub = sub + 2'd1;
		return 1'b0;
	endfunction

	// One tick of the active phase; returns 1 when the stop condition completes.
	function automatic logic advance_bus(input logic sda);
		logic stopped;
		stopped = 1'b0;
		case (ph)
			PH_START_A: if (gen_start()) open_phase(PH_ADDR_W);
			PH_ADDR_W:  if (shift_out_bit()) open_phase(PH_ACK_A);
			PH_ACK_A:   if (target_ack(sda)) open_phase(PH_REG);
			PH_REG:     if (shift_out_bit()) open_phase(PH_ACK_R);
			PH_ACK_R:   if (target_ack(sda)) open_phase(rd_mode ? PH_START_B : PH_DATA);
			PH_DATA:    if (shift_out_bit()) open_phase(PH_ACK_D);
			PH_ACK_D:   if (target_ack(sda)) open_phase(PH_STOP);
			PH_START_B: if (gen_start()) open_phase(PH_ADDR_R);
			PH_ADDR_R:  if (shift_out_bit()) open_phase(PH_ACK_B);
			PH_ACK_B:   if (target_ack(sda)) open_phase(PH_RECV);
			PH_RECV:    if (shift_in_bit(sda)) open_phase(PH_MNACK);
			PH_MNACK:   if (master_nack()) open_phase(PH_STOP);
			PH_STOP: begin
				if (gen_stop()) begin
					open_phase(PH_IDLE);
					stopped = 1'b1;
				end
			end
			default: ph = PH_IDLE;
		endcase
		return stopped;
	endfunction

	function automatic result_t predict_pins(input tick_t t);
		result_t r;
		logic    stopped;
		stopped = 1'b0;
		if (ph == PH_IDLE || ph > PH_MNACK) begin
			ph = PH_IDLE;
			if (t.command == CMD_WRITE || t.command == CMD_READ) begin
				hold_reg  = t.reg_addr;
				hold_dat  = t.write_data;
				rd_mode   = (t.command == CMD_READ);
				ack_fault = 1'b0;
				open_phase(PH_START_A);
				stopped = advance_bus(t.sda_in);
			end
		end else begin
			stopped = advance_bus(t.sda_in);
		end
		r.scl_out   = scl_lvl;
		r.sda_out   = sda_lvl;
		r.busy_res  = (ph != PH_IDLE);
		r.done_res  = stopped;
		r.read_data = rx_byte;
		r.nack_seen = ack_fault;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph        = PH_IDLE;
			sub       = '0;
			nbits     = '0;
			shreg     = '0;
			hold_reg  = '0;
			hold_dat  = '0;
			rd_mode   = 1'b0;
			rx_byte   = '0;
			ack_fault = 1'b0;
			scl_lvl   = 1'b1;
			sda_lvl   = 1'b1;
			target    = SLAVE_ADDR_RESET;
			pin_results_q.delete();
		end else begin
			// Results belong to earlier ticks, so they are retired before this edge's tick is added.
			if (rsp_valid && rsp_ready) begin
				if (pin_results_q.size() == 0) begin
					$error("result transaction arrived with no tick waiting for it");
					mismatches++;
				end else begin
					due = pin_results_q.pop_front();
					check_field("scl_out", 8'(due.scl_out), 8'(rsp_data.scl_out));
					check_field("sda_out", 8'(due.sda_out), 8'(rsp_data.sda_out));
					check_field("busy_res", 8'(due.busy_res), 8'(rsp_data.busy_res));
					check_field("done_res", 8'(due.done_res), 8'(rsp_data.done_res));
					check_field("read_data", due.read_data, rsp_data.read_data);
					check_field("nack_seen", 8'(due.nack_seen), 8'(rsp_data.nack_seen));
				end
			end
			// A tick taken on the same edge as an address write still sees the old address.
			if (req_valid && req_ready)
				pin_results_q.push_back(predict_pins(req_data));
			if (cfg_valid && cfg_ready)
				target = cfg_data;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the I2C register access master testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import i2cra_pkg::*;

	// A command code the block must treat as a plain tick.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Cycles with no transaction on any channel before the run is declared hung.
	// The slowest legal stretch is a full sender gap plus a full receiver stall,
	// so this limit leaves a wide margin.
	localparam int IDLE_LIMIT = 200;

	// Number of random ticks, split over the target address settings below.
	localparam int RANDOM_TICKS = 240;
	localparam int ADDR_SETTINGS = 2;

	// How the simulated target drives SDA on the ticks of a stretch.
	typedef enum logic [1:0] {
		SDA_LOW,
		SDA_HIGH,
		SDA_NOISE
	} sda_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      calm = 1'b1;
	sda_mode_t sda_mode = SDA_LOW;

	int   fail_count;
	int   pending;
	logic seq_busy;

	i2cra_chan_if #(.payload_t(tick_t))       req_if ();
	i2cra_chan_if #(.payload_t(result_t))     rsp_if ();
	i2cra_chan_if #(.payload_t(slave_addr_t)) cfg_if ();

	always #1 clk = ~clk;

	i2c_register_access_master uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// The checker sees every channel, predicts each result and keeps the failure count.
	i2cra_bus_checker watcher (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_if.valid),
		.req_ready  (req_if.ready),
		.req_data   (req_if.data),
		.rsp_valid  (rsp_if.valid),
		.rsp_ready  (rsp_if.ready),
		.rsp_data   (rsp_if.data),
		.cfg_valid  (cfg_if.valid),
		.cfg_ready  (cfg_if.ready),
		.cfg_data   (cfg_if.data),
		.fail_count (fail_count),
		.pending    (pending),
		.seq_busy   (seq_busy)
	);

	// Each side waits a random number of cycles per transaction, except in calm
	// stretches where both run at full rate.
	function automatic int draw_wait();
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	// The SDA level the target presents on the next tick.
	function automatic logic line_level();
		case (sda_mode)
			SDA_LOW:  return 1'b0;
			SDA_HIGH: return 1'b1;
			default:  return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic tick_t make_tick(input logic [1:0] cmd, input logic [7:0] ra,
		input logic [7:0] wd);
		tick_t t;
		t.command    = cmd;
		t.reg_addr   = ra;
		t.write_data = wd;
		t.sda_in     = line_level();
		return t;
	endfunction

	// Offers one tick and returns at the edge where it is accepted. Valid stays
	// high afterwards, so a following call with no gap streams ticks back to back.
	task automatic send_tick(input tick_t t);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= t;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// Clocks plain ticks until the predicted sequencer is idle, then holds the
	// sender off until every expected result has arrived. Checker status is read
	// on the falling edge, away from the edge on which it changes.
	task automatic settle_bus();
		forever begin
			req_if.valid <= 1'b0;
			@(negedge clk);
			if (!seq_busy && pending == 0)
				break;
			@(posedge clk);
			if (seq_busy)
				send_tick(make_tick(CMD_TICK, 8'($urandom), 8'($urandom)));
		end
		@(posedge clk);
	endtask

	// Starts one register access and runs it through to its stop condition.
	task automatic run_command(input logic [1:0] cmd, input logic [7:0] ra,
		input logic [7:0] wd);
		send_tick(make_tick(cmd, ra, wd));
		settle_bus();
	endtask

	// The target address is only changed while the bus is idle and drained.
	task automatic write_target(input slave_addr_t addr);
		settle_bus();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= addr;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
	endtask

	// Result side: per transaction, stall a random number of cycles, then accept.
	initial begin
		int w;
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			w = draw_wait();
			if (w > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	// Watchdog: any cycle with a transaction on some channel restarts the count.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		do begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end while (idle_cycles < IDLE_LIMIT);
		$display("i2c_register_access_master verification failed");
		$finish;
	end

	initial begin
		slave_addr_t addr_plan[ADDR_SETTINGS];
		int          r;
		logic [1:0]  cmd;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first at the reset address and at full rate.
		// An idle tick and an idle tick with the unused command code must both
		// leave the lines released and the block idle.
		calm = 1'b1;
		sda_mode = SDA_LOW;
		send_tick(make_tick(CMD_TICK, 8'hFF, 8'hFF));
		send_tick(make_tick(CMD_UNUSED, 8'hFF, 8'hFF));
		// Write with every acknowledge given, lowest register and all-ones data.
		run_command(CMD_WRITE, 8'h00, 8'hFF);
		// Read with the target never answering: every acknowledge is flagged and
		// the received byte is all ones.
		sda_mode = SDA_HIGH;
		run_command(CMD_READ, 8'hFF, 8'h00);

		// Commands offered while a transaction runs must be ignored.
		calm = 1'b0;
		sda_mode = SDA_NOISE;
		send_tick(make_tick(CMD_WRITE, 8'hA5, 8'h5A));
		send_tick(make_tick(CMD_READ, 8'h3C, 8'hC3));
		send_tick(make_tick(CMD_WRITE, 8'h11, 8'h22));
		send_tick(make_tick(CMD_UNUSED, 8'h44, 8'h88));
		settle_bus();

		// Both extremes of the target address. The clean read at the lowest one
		// returns zero, and the write after it must leave read_data alone.
		sda_mode = SDA_LOW;
		write_target(7'h00);
		run_command(CMD_READ, 8'h01, 8'h80);
		write_target(7'h7F);
		sda_mode = SDA_NOISE;
		run_command(CMD_WRITE, 8'h7F, 8'h01);
		run_command(CMD_READ, 8'h80, 8'hFE);

		// Random part: two address settings, each with a stream of ticks.
		// Roughly one tick in eight carries a command, so a new access starts a
		// few ticks after the last one stops, and most commands land mid-transfer.
		addr_plan[0] = 7'h55;
		addr_plan[1] = 7'($urandom);
		for (int s = 0; s < ADDR_SETTINGS; s++) begin
			write_target(addr_plan[s]);
			calm = (s == 1);
			for (int n = 0; n < RANDOM_TICKS / ADDR_SETTINGS; n++) begin
				if (n % 64 == 0)
					sda_mode = sda_mode_t'($urandom_range(0, 2));
				r = $urandom_range(0, 15);
				if (r == 0)
					cmd = CMD_WRITE;
				else if (r == 1)
					cmd = CMD_READ;
				else if (r == 2)
					cmd = CMD_UNUSED;
				else
					cmd = CMD_TICK;
				send_tick(make_tick(cmd, 8'($urandom), 8'($urandom)));
			end
		end

		// Let the last access finish, drain every result and allow a few more
		// cycles for anything unexpected to show up.
		calm = 1'b0;
		settle_bus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("i2c_register_access_master verification clean");
		end else begin
			$display("i2c_register_access_master verification failed");
		end
		$finish;
	end

endmodule
